// ===== sv/bhsp_pkg.sv =====
package bhsp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned LenW   = 32;
    localparam int unsigned PosW   = 10;
    localparam int unsigned CountW = 8;
    localparam int unsigned SizeW  = 3;
    localparam int unsigned DataW  = 32;
    localparam int unsigned AddrW  = 4;

    localparam logic [ByteW-1:0] StopBit  = 8'h80;
    localparam logic [ByteW-1:0] DataBits = 8'h7F;

    typedef enum logic [1:0] {
        REG_HEADER_MODE     = 2'd0,
        REG_PREFIX_COUNT    = 2'd1,
        REG_SIZE_BYTE_COUNT = 2'd2,
        REG_SUFFIX_COUNT    = 2'd3
    } t_reg_idx;

    typedef enum logic {
        MODE_FIXED    = 1'b0,
        MODE_STOP_BIT = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode              header_mode;
        logic [CountW-1:0]  prefix_count;
        logic [SizeW-1:0]   size_byte_count;
        logic [CountW-1:0]  suffix_count;
    } t_cfg;

endpackage

// ===== sv/bhsp_if.sv =====
interface bhsp_byte_if;
    logic                       valid;
    logic                       ready;
    logic [bhsp_pkg::ByteW-1:0] header_byte;

    modport source (output valid, output header_byte, input ready);
    modport sink (input valid, input header_byte, output ready);
endinterface

interface bhsp_len_if;
    logic                      valid;
    logic                      ready;
    logic [bhsp_pkg::LenW-1:0] block_length;

    modport source (output valid, output block_length, input ready);
    modport sink (input valid, input block_length, output ready);
endinterface

// ===== sv/bhsp_apb_regs.sv =====
module bhsp_apb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bhsp_pkg::AddrW-1:0] paddr,
    input  logic [bhsp_pkg::DataW-1:0] pwdata,
    output logic [bhsp_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output bhsp_pkg::t_cfg             o_cfg
);
    import bhsp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[AddrW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mode     <= MODE_STOP_BIT;
            r_cfg.prefix_count    <= '0;
            r_cfg.size_byte_count <= SizeW'(4);
            r_cfg.suffix_count    <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HEADER_MODE:     r_cfg.header_mode     <= t_mode'(pwdata[0]);
                REG_PREFIX_COUNT:    r_cfg.prefix_count    <= pwdata[CountW-1:0];
                REG_SIZE_BYTE_COUNT: r_cfg.size_byte_count <= pwdata[SizeW-1:0];
                REG_SUFFIX_COUNT:    r_cfg.suffix_count    <= pwdata[CountW-1:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HEADER_MODE:     prdata = DataW'(r_cfg.header_mode);
            REG_PREFIX_COUNT:    prdata = DataW'(r_cfg.prefix_count);
            REG_SIZE_BYTE_COUNT: prdata = DataW'(r_cfg.size_byte_count);
            REG_SUFFIX_COUNT:    prdata = DataW'(r_cfg.suffix_count);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== sv/bhsp_core.sv =====
module bhsp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bhsp_pkg::t_cfg i_cfg,
    bhsp_byte_if.sink      i_hdr,
    bhsp_len_if.source     o_len
);
    import bhsp_pkg::*;

    // input register
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;

    // parse state
    logic             r_in_header;
    logic [PosW-1:0]  r_pos;
    logic [LenW-1:0]  r_acc;

    // result register
    logic             r_out_valid;
    logic [LenW-1:0]  r_out_len;

    logic             take;
    logic             stop;
    logic [PosW-1:0]  pos0;
    logic [LenW-1:0]  acc0;
    logic [PosW-1:0]  prefix;
    logic [PosW-1:0]  size_end;
    logic [PosW-1:0]  fix_total;
    logic [PosW-1:0]  stop_total;
    logic [PosW-1:0]  pos_inc;
    logic [PosW-1:0]  n_pos;
    logic [LenW-1:0]  n_acc;
    logic             done;

    assign take        = r_in_valid && (!r_out_valid || o_len.ready);
    assign i_hdr.ready = !r_in_valid || take;

    assign o_len.valid        = r_out_valid;
    assign o_len.block_length = r_out_len;

    assign stop       = (r_in_byte & StopBit) != '0;
    assign pos0       = r_in_header ? r_pos : '0;
    assign acc0       = r_in_header ? r_acc : '0;
    assign prefix     = PosW'(i_cfg.prefix_count);
    assign size_end   = prefix + PosW'(i_cfg.size_byte_count);
    assign fix_total  = size_end + PosW'(i_cfg.suffix_count);
    assign stop_total = prefix + PosW'(1) + PosW'(i_cfg.suffix_count);
    assign pos_inc    = pos0 + PosW'(1);

    always_comb begin
        n_pos = pos0;
        n_acc = acc0;
        done  = 1'b0;
        if (i_cfg.header_mode == MODE_FIXED) begin
            if (pos0 >= prefix && pos0 < size_end) begin
                n_acc = {acc0[LenW-ByteW-1:0], r_in_byte};
            end
            n_pos = pos_inc;
            done  = pos_inc >= fix_total;
        end else begin
            if (pos0 < prefix) begin
                if (stop) begin
                    n_pos = pos_inc;
                end
            end else if (pos0 == prefix) begin
                // seven data bits per byte, old top bits fall off
                n_acc = {acc0[LenW-8:0], r_in_byte[6:0] & DataBits[6:0]};
                if (stop) begin
                    n_pos = pos_inc;
                    done  = i_cfg.suffix_count == '0;
                end
            end else begin
                if (stop) begin
                    n_pos = pos_inc;
                    done  = pos_inc >= stop_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_header <= 1'b0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_hdr.ready) begin
                r_in_valid <= i_hdr.valid;
            end
            if (take) begin
                r_in_header <= !done;
                r_pos       <= done ? '0 : n_pos;
                r_acc       <= n_acc;
                r_out_valid <= done;
            end else if (o_len.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hdr.ready && i_hdr.valid) begin
            r_in_byte <= i_hdr.header_byte;
        end
        if (take && done) begin
            r_out_len <= n_acc;
        end
    end

endmodule

// ===== sv/block_header_size_parser.sv =====
// block header size parser
// header bytes come in one word at a time on i_hdr (valid/ready); each
// finished header gives one word on o_len carrying the decoded block length.
// mode and counts must be set over the apb port while the parser is idle:
// fixed mode skips prefix bytes, gathers size bytes msb first, skips suffix
// bytes; stop-bit mode counts fields ending in a byte with bit 7 set and
// gathers seven bits from each byte of the size field.
// the parser itself does not enforce the idle rule. one byte is taken every
// cycle while o_len is not stalled; the byte that ends a header passes the
// input register, then its length is held in the result register on o_len.
// the result register and the input register together keep the input side
// running while a result waits; when o_len is stalled and both registers
// are full, i_hdr.ready drops until the result is taken.
// synchronous reset puts the registers to stop-bit mode, no prefix or
// suffix, four size bytes, and drops any partly parsed header.
module block_header_size_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bhsp_byte_if.sink                  i_hdr,
    bhsp_len_if.source                 o_len,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bhsp_pkg::AddrW-1:0] paddr,
    input  logic [bhsp_pkg::DataW-1:0] pwdata,
    output logic [bhsp_pkg::DataW-1:0] prdata,
    output logic                       pready
);
    import bhsp_pkg::*;

    t_cfg cfg;

    bhsp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bhsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_hdr   (i_hdr),
        .o_len   (o_len)
    );

endmodule

// ===== tb/sv/bhsp_length_checker.sv =====
module bhsp_length_checker
    import bhsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    bhsp_byte_if             hdr,
    bhsp_len_if              len,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    input  logic             pready,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg            cfg;
    logic [PosW-1:0] hdr_pos;
    logic [LenW-1:0] size_acc;
    bit              in_hdr;
    logic [LenW-1:0] lengths_due[$];

    // returns 1 when this byte closes the header, with the decoded length
    function automatic bit decode_header_byte(input logic [ByteW-1:0] b,
                                              output logic [LenW-1:0] length);
        logic [PosW-1:0] prefix;
        logic [PosW-1:0] size_end;
        logic [PosW-1:0] total;
        bit              stop;
        bit              done;
        stop   = (b & StopBit) != 0;
        done   = 1'b0;
        length = '0;
        prefix = PosW'(cfg.prefix_count);
        if (!in_hdr) begin
            in_hdr   = 1'b1;
            size_acc = '0;
            hdr_pos  = '0;
        end
        if (cfg.header_mode == MODE_FIXED) begin
            size_end = prefix + PosW'(cfg.size_byte_count);
            total    = size_end + PosW'(cfg.suffix_count);
            if (hdr_pos >= prefix && hdr_pos < size_end) begin
                size_acc = {size_acc[LenW-ByteW-1:0], b};
            end
            hdr_pos = hdr_pos + PosW'(1);
            done    = hdr_pos >= total;
        end else begin
            total = prefix + PosW'(cfg.suffix_count) + PosW'(1);
            if (hdr_pos < prefix) begin
                if (stop) hdr_pos = hdr_pos + PosW'(1);
            end else if (hdr_pos == prefix) begin
                // seven data bits per byte, anything above bit 31 drops off
                size_acc = {size_acc[LenW-8:0], b[6:0] & DataBits[6:0]};
                if (stop) begin
                    hdr_pos = hdr_pos + PosW'(1);
                    done    = cfg.suffix_count == 0;
                end
            end else if (stop) begin
                // a position past the size field counts as suffix
                hdr_pos = hdr_pos + PosW'(1);
                done    = hdr_pos >= total;
            end
        end
        if (done) begin
            length  = size_acc;
            in_hdr  = 1'b0;
            hdr_pos = '0;
        end
        return done;
    endfunction

    always @(posedge i_clk) begin
        logic [LenW-1:0] length;
        logic [LenW-1:0] want;
        if (!i_rst_n) begin
            cfg.header_mode     = MODE_STOP_BIT;
            cfg.prefix_count    = '0;
            cfg.size_byte_count = 3'd4;
            cfg.suffix_count    = '0;
            hdr_pos             = '0;
            size_acc            = '0;
            in_hdr              = 1'b0;
            lengths_due.delete();
            o_errors            = 0;
            o_checked           = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_HEADER_MODE:     cfg.header_mode     = t_mode'(pwdata[0]);
                    REG_PREFIX_COUNT:    cfg.prefix_count    = pwdata[CountW-1:0];
                    REG_SIZE_BYTE_COUNT: cfg.size_byte_count = pwdata[SizeW-1:0];
                    REG_SUFFIX_COUNT:    cfg.suffix_count    = pwdata[CountW-1:0];
                    default: ;
                endcase
            end
            // compare first: a length can never come from the byte taken on this edge
            if (len.valid && len.ready) begin
                o_checked = o_checked + 1;
                if (lengths_due.size() == 0) begin
                    $display("%0t: unexpected block_length word %h", $time, len.block_length);
                    o_errors = o_errors + 1;
                end else begin
                    want = lengths_due.pop_front();
                    if (len.block_length !== want) begin
                        $display("%0t: block_length mismatch: expected %h got %h",
                                 $time, want, len.block_length);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (hdr.valid && hdr.ready) begin
                if (decode_header_byte(hdr.header_byte, length)) begin
                    lengths_due.push_back(length);
                end
            end
        end
        o_pending = lengths_due.size();
    end

endmodule

// ===== tb/sv/block_header_size_parser_test.sv =====
module block_header_size_parser_test;
    import bhsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 4000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    int errors;
    int pending;
    int checked;
    int bytes_sent;
    int settings;
    int phase_no;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    t_mode cur_mode;
    int    cur_pre;
    int    cur_sbc;
    int    cur_suf;

    bhsp_byte_if hdr_if ();
    bhsp_len_if  len_if ();

    block_header_size_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_if),
        .o_len   (len_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bhsp_length_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .hdr       (hdr_if),
        .len       (len_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        len_if.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (hdr_if.valid && hdr_if.ready)
            || (len_if.valid && len_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("[block_header_size_parser] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // entered and left on a falling edge; valid stays high after the word
    task automatic push_byte(input logic [ByteW-1:0] b);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            hdr_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        hdr_if.valid       <= 1'b1;
        hdr_if.header_byte <= b;
        @(posedge i_clk);
        while (!hdr_if.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // all lengths in, then a wait for a byte still in the input register to be taken
    task automatic wait_idle();
        hdr_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_cfg(input t_mode mode, input int pre, input int sbc, input int suf);
        wait_idle();
        cfg_write(REG_HEADER_MODE, mode);
        cfg_write(REG_PREFIX_COUNT, pre);
        cfg_write(REG_SIZE_BYTE_COUNT, sbc);
        cfg_write(REG_SUFFIX_COUNT, suf);
        cur_mode = mode;
        cur_pre  = pre;
        cur_sbc  = sbc;
        cur_suf  = suf;
        settings++;
    endtask

    // one stop-bit field: n bytes, only the last with bit 7 set
    task automatic send_field(input int n);
        logic [ByteW-1:0] b;
        for (int i = 0; i < n; i++) begin
            b = ByteW'($urandom_range(0, 127));
            if (i == n - 1) b = b | StopBit;
            push_byte(b);
        end
    endtask

    function automatic int skip_field_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    endfunction

    task automatic send_header();
        int n;
        if (cur_mode == MODE_FIXED) begin
            n = cur_pre + cur_sbc + cur_suf;
            if (n == 0) n = 1;
            repeat (n) push_byte(ByteW'($urandom_range(0, 255)));
        end else begin
            repeat (cur_pre) send_field(skip_field_len());
            // now and then a size field long enough to overflow 32 bits
            send_field(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                    : $urandom_range(1, 4));
            repeat (cur_suf) send_field(skip_field_len());
        end
    endtask

    task automatic run_phase(input t_mode mode, input int pre, input int sbc, input int suf,
                             input int budget);
        int start;
        set_cfg(mode, pre, sbc, suf);
        case (phase_no % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 66; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 66; end
            default: begin idle_pct = 28; stall_pct = 28; end
        endcase
        phase_no++;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            // stray bytes break up headers and leave some phases mid-header
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 3)) push_byte(ByteW'($urandom_range(0, 255)));
            end else begin
                send_header();
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        hdr_if.valid       = 1'b0;
        hdr_if.header_byte = '0;
        len_if.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        idle_pct           = 0;
        stall_pct          = 0;
        bytes_sent         = 0;
        settings           = 0;
        phase_no           = 0;
        cur_mode           = MODE_STOP_BIT;
        cur_pre            = 0;
        cur_sbc            = 4;
        cur_suf            = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: stop-bit, size field only
        push_byte(8'h81);
        push_byte(8'h7F);
        push_byte(8'hFF);
        repeat (4) push_byte(8'h7F);
        push_byte(8'hFF);
        // empty fixed header: every byte closes one
        set_cfg(MODE_FIXED, 0, 0, 0);
        push_byte(8'hFF);
        push_byte(8'h00);
        set_cfg(MODE_FIXED, 0, 4, 0);
        push_byte(8'h12);
        push_byte(8'h34);
        push_byte(8'h56);
        push_byte(8'h78);
        // no size bytes between prefix and suffix
        set_cfg(MODE_FIXED, 1, 0, 1);
        push_byte(8'hAA);
        push_byte(8'hBB);
        // more than four size bytes, top ones lost
        set_cfg(MODE_FIXED, 0, 5, 0);
        for (int i = 1; i <= 5; i++) push_byte(ByteW'(i));
        // shorten the header while in the middle of one
        set_cfg(MODE_FIXED, 0, 4, 0);
        push_byte(8'hC3);
        push_byte(8'h3C);
        set_cfg(MODE_FIXED, 0, 1, 0);
        push_byte(8'h99);
        // switch mode part way through a stop-bit header
        set_cfg(MODE_STOP_BIT, 1, 2, 1);
        push_byte(8'h05);
        push_byte(8'h85);
        push_byte(8'h11);
        set_cfg(MODE_FIXED, 1, 2, 1);
        push_byte(8'h22);
        push_byte(8'h33);

        run_phase(MODE_FIXED, 0, 4, 0, 60);
        run_phase(MODE_STOP_BIT, 0, 4, 0, 60);
        run_phase(MODE_FIXED, 0, 1, 0, 60);
        run_phase(MODE_STOP_BIT, 2, 4, 1, 60);
        run_phase(MODE_FIXED, 255, 2, 0, 250);
        run_phase(MODE_STOP_BIT, 0, 4, 255, 250);
        run_phase(MODE_FIXED, 0, 0, 0, 60);
        run_phase(MODE_FIXED, 1, 7, 2, 60);
        run_phase(MODE_STOP_BIT, 1, 1, 0, 60);
        for (int p = 0; p < 6; p++) begin
            run_phase(t_mode'($urandom_range(0, 1)), $urandom_range(0, 3),
                      $urandom_range(0, 7), $urandom_range(0, 3), 60);
        end
        wait_idle();

        $display("%0d header bytes sent under %0d register settings in both modes,",
                 bytes_sent, settings);
        $display("%0d block lengths checked with sender gaps and receiver stalls",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("[block_header_size_parser] OK");
        end else begin
            $display("[block_header_size_parser] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bhsp_pkg.sv
sv/bhsp_if.sv
sv/bhsp_apb_regs.sv
sv/bhsp_core.sv
sv/block_header_size_parser.sv
tb/sv/bhsp_length_checker.sv
tb/sv/block_header_size_parser_test.sv
